>>> rtl/s8rfp_pkg.sv
package s8rfp_pkg;

    // Parser phases.
    localparam logic [2:0] PH_WAIT    = 3'd0;
    localparam logic [2:0] PH_CMD     = 3'd1;
    localparam logic [2:0] PH_COUNT   = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;
    localparam logic [2:0] PH_STOP    = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] REG_START_MARKER = 2'd0;
    localparam logic [1:0] REG_STOP_MARKER  = 2'd1;
    localparam logic [1:0] REG_ALARM_CODE   = 2'd2;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 32;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

>>> rtl/sum8_response_frame_parser.sv
// Byte-serial response frame parser with an 8-bit additive checksum.
//
// Received bytes enter on the input channel (in_valid, in_ready, rx_byte),
// one item per byte. A frame is a start marker, a command byte, a payload
// count, that many payload bytes, a checksum byte and a stop byte. Bytes seen
// while no frame is open and which do not match the start marker are dropped.
// When the stop byte is taken, one result item appears on the output channel
// (out_valid, out_ready and the result fields) in the following cycle.
//
// Each byte updates a handful of parser registers with one 8-bit add and a
// few compares, so an item can be accepted in every cycle while in_ready is
// high: one byte per clock. The result sits in an output register; while it
// waits to be taken, in_ready stays high only if out_ready is high too, so a
// stalled receiver holds the parser after at most one completed frame.
//
// The configuration port (cfg_write, cfg_index, cfg_data) sets the start
// marker, the stop marker and the alarm command code. Asynchronous reset
// clears the parser to waiting for a start marker, clears all three
// registers and empties the output register.
module sum8_response_frame_parser
    import s8rfp_pkg::*;
#(
    parameter int VALUE_BYTES = 4
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [BYTE_W-1:0]   cfg_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   rx_byte,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [BYTE_W-1:0]   command,
    output logic [BYTE_W-1:0]   payload_count,
    output logic [VALUE_W-1:0]  value,
    output logic                checksum_good,
    output logic                stop_good
);

    // Only the first VALUE_BYTES payload bytes, at most four, fit in the 32-bit value.
    localparam int USED_BYTES = (VALUE_BYTES < 4) ? VALUE_BYTES : 4;
    localparam int ASM_W      = BYTE_W * USED_BYTES;
    localparam int IDX_W      = $clog2(USED_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(USED_BYTES);

    // Configuration registers.
    byte_t start_marker_reg;
    byte_t stop_marker_reg;
    byte_t alarm_code_reg;

    // Parser state.
    logic [2:0]       phase_reg,     phase_next;
    byte_t            frame_cmd_reg, frame_cmd_next;
    byte_t            count_reg,     count_next;
    byte_t            left_reg,      left_next;
    logic [IDX_W-1:0] index_reg,     index_next;
    byte_t            sum_reg,       sum_next;
    logic [ASM_W-1:0] asm_reg,       asm_next;
    logic             match_reg,     match_next;

    // Output register.
    logic             out_valid_reg;
    byte_t            command_reg;
    byte_t            payload_count_reg;
    logic [VALUE_W-1:0] value_reg;
    logic             checksum_good_reg;
    logic             stop_good_reg;

    logic  in_fire;
    logic  emit;
    byte_t sum_plus;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign sum_plus = sum_reg + rx_byte;
    assign emit     = in_fire && (phase_reg == PH_STOP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= '0;
            stop_marker_reg  <= '0;
            alarm_code_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_START_MARKER: start_marker_reg <= cfg_data;
                REG_STOP_MARKER:  stop_marker_reg  <= cfg_data;
                REG_ALARM_CODE:   alarm_code_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Next state for the byte being accepted.
    always_comb
    begin
        phase_next     = phase_reg;
        frame_cmd_next = frame_cmd_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        index_next     = index_reg;
        sum_next       = sum_reg;
        asm_next       = asm_reg;
        match_next     = match_reg;

        unique case (phase_reg)
            PH_CMD:
            begin
                frame_cmd_next = rx_byte;
                sum_next       = sum_plus;
                phase_next     = PH_COUNT;
            end
            PH_COUNT:
            begin
                count_next = rx_byte;
                left_next  = rx_byte;
                index_next = '0;
                asm_next   = '0;
                sum_next   = sum_plus;
                phase_next = (rx_byte == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                sum_next = sum_plus;
                for (int k = 0; k < USED_BYTES; k++)
                begin
                    if (index_reg == IDX_W'(k))
                    begin
                        asm_next[k*BYTE_W +: BYTE_W] = rx_byte;
                    end
                end
                // The index saturates once every value byte is filled.
                if (index_reg != IDX_FULL)
                begin
                    index_next = index_reg + 1'b1;
                end
                left_next = left_reg - 1'b1;
                if (left_reg == 8'd1)
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                match_next = (sum_reg == rx_byte);
                phase_next = PH_STOP;
            end
            PH_STOP:
            begin
                phase_next = PH_WAIT;
            end
            default:
            begin
                // Waiting for a start marker; unused codes behave the same.
                if (rx_byte == start_marker_reg)
                begin
                    sum_next       = rx_byte;
                    frame_cmd_next = '0;
                    count_next     = '0;
                    left_next      = '0;
                    index_next     = '0;
                    asm_next       = '0;
                    match_next     = 1'b0;
                    phase_next     = PH_CMD;
                end
                else
                begin
                    phase_next = PH_WAIT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_WAIT;
            frame_cmd_reg <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            index_reg     <= '0;
            sum_reg       <= '0;
            asm_reg       <= '0;
            match_reg     <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg     <= phase_next;
            frame_cmd_reg <= frame_cmd_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            index_reg     <= index_next;
            sum_reg       <= sum_next;
            asm_reg       <= asm_next;
            match_reg     <= match_next;
        end
    end

    // Result register: loaded on the stop byte, held until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            command_reg       <= frame_cmd_reg;
            payload_count_reg <= count_reg;
            value_reg         <= (frame_cmd_reg == alarm_code_reg) ? '0
                                 : VALUE_W'(asm_reg);
            checksum_good_reg <= match_reg;
            stop_good_reg     <= (rx_byte == stop_marker_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign command       = command_reg;
    assign payload_count = payload_count_reg;
    assign value         = value_reg;
    assign checksum_good = checksum_good_reg;
    assign stop_good     = stop_good_reg;

    // A stop byte always leaves a result behind it.
    a_stop_emits: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("stop byte accepted but no result registered");

    // A fresh result can only come from a stop byte.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(phase_reg) == PH_STOP)
        else $error("result raised outside the stop phase");

    // The last payload byte moves the parser to the checksum byte.
    a_payload_end: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && phase_reg == PH_PAYLOAD && left_reg == 8'd1)
            |=> phase_reg == PH_CHECK)
        else $error("payload did not end on its announced count");

endmodule
